>>> hdl/sbd_pkg.sv
package sbd_pkg;

   localparam int unsigned MAX_WIDTH_DEF   = 4096;
   localparam int unsigned LINEAR_BITS_DEF = 16;
   localparam int unsigned MAX_HEIGHT      = 4096;
   localparam int unsigned HEIGHT_BITS     = 13;
   localparam int unsigned ROW_BITS        = 12;
   localparam int unsigned CSR_DATA_BITS   = 13;
   localparam int unsigned CSR_INDEX_BITS  = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_SRGB_MODE    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic       last;
      logic       mode;
      logic [7:0] alpha;
   } side_type;

   // shift-subtract division for table building
   function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((a >> i) & 64'd1);
         if (r >= b) begin
            r = r - b;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   function automatic longint unsigned pow5_q30(longint unsigned r);
      longint unsigned r2;
      longint unsigned r4;
      r2 = (r * r) >> 30;
      r4 = (r2 * r2) >> 30;
      return (r4 * r) >> 30;
   endfunction

   function automatic longint unsigned formula_q30(longint unsigned num, longint unsigned den);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      if (num * 64'd100000 <= 64'd4045 * den)
         return udiv((num * 64'd100) << 30, 64'd1292 * den);
      x = udiv((64'd1000 * num + 64'd55 * den) << 30, 64'd1055 * den);
      if (x > (64'd1 << 30))
         x = 64'd1 << 30;
      x2 = (x * x) >> 30;
      for (int b = 30; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand <= (64'd1 << 30) && pow5_q30(cand) <= x2)
            r = cand;
      end
      return (x2 * r) >> 30;
   endfunction

   function automatic longint unsigned dec_value(int unsigned v, int unsigned lbits);
      longint unsigned l;
      longint unsigned d;
      longint unsigned lmax;
      l    = formula_q30(longint'(v), 64'd255);
      d    = (l + (64'd1 << (30 - lbits - 1))) >> (30 - lbits);
      lmax = (64'd1 << lbits) - 64'd1;
      return (d > lmax) ? lmax : d;
   endfunction

   function automatic longint unsigned thr_value(int unsigned c, int unsigned lbits);
      longint unsigned l;
      if (c == 0)
         return 64'd0;
      l = formula_q30(longint'(2 * c - 1), 64'd510);
      return (l + (64'd1 << (30 - lbits)) - 64'd1) >> (30 - lbits);
   endfunction

endpackage

>>> hdl/srgb_box_downsample_2x2.sv
// 2x2 box downsampler for RGBA8 raster streams: one beat in per clock while no result waits
// on rsp_stall, one beat out per 2x2 source block, registered through a pair stage, a mean
// stage and the encode steps. Odd rows read pair sums that even rows left in a line memory
// of MAX_WIDTH/2 entries; every stage moves together and holds while a result waits on
// rsp_stall. Write image_width, image_height and srgb_mode only between images. In sRGB mode
// the re-encode is an eight-step threshold search, one step per pipeline stage.
module srgb_box_downsample_2x2 #(
   parameter int unsigned MAX_WIDTH   = sbd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned LINEAR_BITS = sbd_pkg::LINEAR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_in_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_out_pixel,
   output logic                                 rsp_last_of_image,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sbd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int unsigned CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned DEPTH = MAX_WIDTH / 2;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LB    = LINEAR_BITS;
   localparam int unsigned PW    = LB + 1;
   localparam int unsigned BW    = LB + 2;
   localparam int unsigned EW    = 3 * PW + 9;
   localparam int unsigned HB    = sbd_pkg::HEIGHT_BITS;
   localparam int unsigned RB    = sbd_pkg::ROW_BITS;

   logic [LB-1:0] dec_rom [256];

   for (genvar i = 0; i < 256; i++) begin : g_dec
      localparam logic [LB-1:0] D = LB'(sbd_pkg::dec_value(i, LB));
      assign dec_rom[i] = D;
   end

   logic [CW:0]   width_ff;
   logic [HB-1:0] height_ff;
   logic          mode_ff;
   logic [CW-1:0] col_ff;
   logic [RB-1:0] row_ff;
   logic [LB-1:0] held_ff [4];

   logic          en;
   logic          accept;
   logic          enc_valid;

   assign csr_ready = 1'b1;
   assign en        = !(enc_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= (CW + 1)'(1);
         height_ff <= HB'(1);
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (sbd_pkg::reg_index_type'(csr_index))
            sbd_pkg::REG_IMAGE_WIDTH: begin
               if (csr_data == '0)
                  width_ff <= (CW + 1)'(1);
               else if (32'(csr_data) > 32'(MAX_WIDTH))
                  width_ff <= (CW + 1)'(MAX_WIDTH);
               else
                  width_ff <= (CW + 1)'(csr_data);
            end
            sbd_pkg::REG_IMAGE_HEIGHT: begin
               if (csr_data == '0)
                  height_ff <= HB'(1);
               else if (32'(csr_data) > 32'(sbd_pkg::MAX_HEIGHT))
                  height_ff <= HB'(sbd_pkg::MAX_HEIGHT);
               else
                  height_ff <= csr_data;
            end
            sbd_pkg::REG_SRGB_MODE: begin
               mode_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   logic [CW:0]   half_w;
   logic [CW:0]   new_w;
   logic [HB-1:0] half_h;
   logic [HB-1:0] new_h;
   logic          w_one;
   logic          h_one;

   assign half_w = width_ff >> 1;
   assign new_w  = (half_w == '0) ? (CW + 1)'(1) : half_w;
   assign half_h = height_ff >> 1;
   assign new_h  = (half_h == '0) ? HB'(1) : half_h;
   assign w_one  = (width_ff == (CW + 1)'(1));
   assign h_one  = (height_ff == HB'(1));

   logic [LB-1:0] v [4];
   logic [PW-1:0] pair [4];
   logic          col_live;
   logic          row_live;
   logic          have_pair;
   logic [CW-1:0] x;
   logic [RB-1:0] y;
   logic          last_blk;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (k < 3 && mode_ff)
            v[k] = dec_rom[req_in_pixel[8*k +: 8]];
         else
            v[k] = LB'(req_in_pixel[8*k +: 8]);
         if (w_one)
            pair[k] = {v[k], 1'b0};
         else
            pair[k] = PW'(held_ff[k]) + PW'(v[k]);
      end
   end

   assign col_live  = ({1'b0, col_ff} < (new_w << 1));
   assign row_live  = ({1'b0, row_ff} < (new_h << 1));
   assign have_pair = w_one || (col_live && col_ff[0]);
   assign x         = w_one ? '0 : (col_ff >> 1);
   assign y         = h_one ? '0 : (row_ff >> 1);
   assign last_blk  = ({1'b0, x} == new_w - (CW + 1)'(1)) &&
                      ({1'b0, y} == new_h - HB'(1));

   always_ff @(posedge clock) begin
      if (accept && !w_one && col_live && !col_ff[0]) begin
         for (int k = 0; k < 4; k++) begin
            held_ff[k] <= v[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (({1'b0, col_ff} + (CW + 1)'(1)) >= width_ff) begin
            col_ff <= '0;
            if (({1'b0, row_ff} + HB'(1)) >= height_ff)
               row_ff <= '0;
            else
               row_ff <= row_ff + RB'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   logic          s1_val_ff;
   logic          s1_h1_ff;
   logic          s1_odd_ff;
   logic          s1_last_ff;
   logic [AW-1:0] s1_x_ff;
   logic [PW-1:0] s1_pair_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_val_ff <= 1'b0;
      end else if (en) begin
         s1_val_ff <= accept && have_pair && (h_one || row_live);
      end
      if (en) begin
         s1_h1_ff   <= h_one;
         s1_odd_ff  <= row_ff[0];
         s1_last_ff <= last_blk;
         s1_x_ff    <= AW'(x);
         for (int k = 0; k < 4; k++) begin
            s1_pair_ff[k] <= pair[k];
         end
      end
   end

   logic [EW-1:0] line_mem [DEPTH];
   logic [EW-1:0] rd_ff;
   logic [EW-1:0] wr_data;
   logic          wr_en;
   logic [AW-1:0] rd_addr;

   assign wr_en   = en && s1_val_ff && !s1_h1_ff && !s1_odd_ff;
   assign wr_data = {s1_pair_ff[3][8:0], s1_pair_ff[2], s1_pair_ff[1], s1_pair_ff[0]};
   assign rd_addr = AW'(x);

   // forward a write that lands on the entry being read in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en)
         line_mem[s1_x_ff] <= wr_data;
      if (en) begin
         if (wr_en && (s1_x_ff == rd_addr))
            rd_ff <= wr_data;
         else
            rd_ff <= line_mem[rd_addr];
      end
   end

   logic [PW-1:0] line_sum [4];
   logic [BW-1:0] blk [4];

   always_comb begin
      line_sum[0] = rd_ff[PW-1:0];
      line_sum[1] = rd_ff[2*PW-1:PW];
      line_sum[2] = rd_ff[3*PW-1:2*PW];
      line_sum[3] = PW'(rd_ff[EW-1:3*PW]);
      for (int k = 0; k < 4; k++) begin
         if (s1_h1_ff)
            blk[k] = {s1_pair_ff[k], 1'b0};
         else
            blk[k] = BW'(line_sum[k]) + BW'(s1_pair_ff[k]);
      end
   end

   logic                  s2_val_ff;
   logic [2:0][LB-1:0]    s2_mean_ff;
   sbd_pkg::side_type     s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_val_ff <= 1'b0;
      end else if (en) begin
         s2_val_ff <= s1_val_ff && (s1_h1_ff || s1_odd_ff);
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s2_mean_ff[k] <= blk[k][BW-1:2];
         end
         s2_side_ff.alpha <= blk[3][9:2];
         s2_side_ff.mode  <= mode_ff;
         s2_side_ff.last  <= s1_last_ff;
      end
   end

   sbd_encode #(
      .LINEAR_BITS(LINEAR_BITS)
   ) u_encode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_val_ff),
      .in_mean   (s2_mean_ff),
      .in_side   (s2_side_ff),
      .out_valid (enc_valid),
      .out_pixel (rsp_out_pixel),
      .out_last  (rsp_last_of_image)
   );

   assign rsp_valid = enc_valid;

endmodule

>>> hdl/sbd_encode.sv
module sbd_encode #(
   parameter int unsigned LINEAR_BITS = sbd_pkg::LINEAR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [2:0][LINEAR_BITS-1:0]   in_mean,
   input  sbd_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [31:0]                   out_pixel,
   output logic                          out_last
);

   localparam int unsigned STEPS = 8;

   logic [LINEAR_BITS:0] thr_rom [256];

   for (genvar i = 0; i < 256; i++) begin : g_thr
      localparam logic [LINEAR_BITS:0] T =
         (LINEAR_BITS + 1)'(sbd_pkg::thr_value(i, LINEAR_BITS));
      assign thr_rom[i] = T;
   end

   logic                          val_ff  [STEPS];
   logic [2:0][LINEAR_BITS-1:0]   mean_ff [STEPS];
   logic [2:0][7:0]               code_ff [STEPS];
   sbd_pkg::side_type             side_ff [STEPS];

   logic                          val_in  [STEPS];
   logic [2:0][LINEAR_BITS-1:0]   mean_in [STEPS];
   logic [2:0][7:0]               code_in [STEPS];
   sbd_pkg::side_type             side_in [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic                        pv;
      logic [2:0][LINEAR_BITS-1:0] pm;
      logic [2:0][7:0]             pc;
      sbd_pkg::side_type           ps;

      if (s == 0) begin : g_first
         assign pv = in_valid;
         assign pm = in_mean;
         assign pc = '0;
         assign ps = in_side;
      end else begin : g_next
         assign pv = val_ff[s-1];
         assign pm = mean_ff[s-1];
         assign pc = code_ff[s-1];
         assign ps = side_ff[s-1];
      end

      for (genvar k = 0; k < 3; k++) begin : g_ch
         logic [7:0] cand;
         logic [7:0] found;
         assign cand  = pc[k] | (8'd1 << (STEPS - 1 - s));
         assign found = ({1'b0, pm[k]} >= thr_rom[cand]) ? cand : pc[k];
         if (s == STEPS - 1) begin : g_pick
            assign code_in[s][k] = ps.mode ? found : pm[k][7:0];
         end else begin : g_keep
            assign code_in[s][k] = found;
         end
      end

      assign val_in[s]  = pv;
      assign mean_in[s] = pm;
      assign side_in[s] = ps;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STEPS; s++) begin
            val_ff[s]  <= val_in[s];
            mean_ff[s] <= mean_in[s];
            code_ff[s] <= code_in[s];
            side_ff[s] <= side_in[s];
         end
      end
      if (reset) begin
         for (int s = 0; s < STEPS; s++) begin
            val_ff[s] <= 1'b0;
         end
      end
   end

   assign out_valid = val_ff[STEPS-1];
   assign out_pixel = {side_ff[STEPS-1].alpha, code_ff[STEPS-1][2],
                       code_ff[STEPS-1][1], code_ff[STEPS-1][0]};
   assign out_last  = side_ff[STEPS-1].last;

endmodule
